/* hdl/tsna_pkg.sv */
// Package with the types and constants shared by the tile-scan address unit.
`timescale 1ns / 1ps

package tsna_pkg;

    // Field widths of the input and result beats.
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 5;
    localparam int SIZE_W   = 10;
    localparam int CUR_W    = 18;
    localparam int NEXT_W   = 19;
    localparam int TILE_W   = 10;

    // Configuration register widths.
    localparam int LUMA_W   = 14;
    localparam int LOG2_W   = 3;
    localparam int TCNT_W   = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // Internal widths: picture size in CTUs and the CTU count.
    localparam int CTU_W    = 14;
    localparam int COUNT_W  = 28;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_W   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_H   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_M1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIFORM = 3'd5;

    // Action codes carried in the input tuser.
    localparam logic [ACTION_W-1:0] ACT_LOAD_COL = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_ROW = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY    = 2'd2;

    // Work kinds after classification by the front end.
    typedef enum logic [1:0] {
        KIND_LOAD_COL = 2'd0,
        KIND_LOAD_ROW = 2'd1,
        KIND_QUERY    = 2'd2,
        KIND_ZERO     = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [INDEX_W-1:0]  index;
        logic [SIZE_W-1:0]   size;
        logic [CUR_W-1:0]    cur;
    } cmd_t;

    typedef struct packed {
        logic [LUMA_W-1:0] pic_w;
        logic [LUMA_W-1:0] pic_h;
        logic [LOG2_W-1:0] log2;
        logic [TCNT_W-1:0] cols_m1;
        logic [TCNT_W-1:0] rows_m1;
        logic              uniform;
    } cfg_t;

    typedef struct packed {
        logic [NEXT_W-1:0] next_addr;
        logic [TILE_W-1:0] tile;
        logic              pic_end;
        logic              err;
    } result_t;

endpackage

/* hdl/tsna_ram.sv */
// Generic single-port-write RAM with a registered read port.
`timescale 1ns / 1ps

module tsna_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/tsna_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tsna_div #(
    parameter int NUM_W = 18,
    parameter int DEN_W = 14
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    // One shift-and-subtract step.
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            cnt_next = CNT_W'(NUM_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next  = {quo_reg[NUM_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

/* hdl/tsna_front.sv */
// Front end: accepts input beats, classifies them and queues the commands.
`timescale 1ns / 1ps

module tsna_front #(
    parameter int MAX_TILE_COLS = 32,
    parameter int MAX_TILE_ROWS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,
    input  logic [tsna_pkg::ACTION_W-1:0]   s_tuser,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output tsna_pkg::cmd_t                  cmd
);

    import tsna_pkg::*;

    cmd_t           q_reg [2];
    logic           wptr_reg, rptr_reg;
    logic [1:0]     cnt_reg, cnt_next;
    cmd_t           in_cmd;
    logic           push, pop;
    logic [INDEX_W-1:0] idx;

    // Classify the incoming beat.
    always_comb
    begin
        idx          = s_tdata[INDEX_W-1:0];
        in_cmd.index = idx;
        in_cmd.size  = s_tdata[INDEX_W+SIZE_W-1:INDEX_W];
        in_cmd.cur   = s_tdata[INDEX_W+SIZE_W+CUR_W-1:INDEX_W+SIZE_W];
        unique case (s_tuser)
            ACT_LOAD_COL:
                in_cmd.kind = (32'(idx) < MAX_TILE_COLS) ? KIND_LOAD_COL : KIND_ZERO;
            ACT_LOAD_ROW:
                in_cmd.kind = (32'(idx) < MAX_TILE_ROWS) ? KIND_LOAD_ROW : KIND_ZERO;
            ACT_QUERY:
                in_cmd.kind = KIND_QUERY;
            default:
                in_cmd.kind = KIND_ZERO;
        endcase
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Two-entry command queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= in_cmd;
        end
    end

endmodule

/* hdl/tsna_back.sv */
// Back end: table loads and the tile-scan address sequencer with result register.
`timescale 1ns / 1ps

module tsna_back #(
    parameter int MAX_TILE_COLS = 32,
    parameter int MAX_TILE_ROWS = 32,
    parameter int ADDR_BITS     = 18
) (
    input  logic            clk,
    input  logic            rst_n,
    input  tsna_pkg::cfg_t  cfg,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  tsna_pkg::cmd_t  cmd,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    import tsna_pkg::*;

    localparam int CIW = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
    localparam int RIW = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(1) << ADDR_BITS;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SIZE  = 11'b00000000010,
        S_CHECK = 11'b00000000100,
        S_XY    = 11'b00000001000,
        S_AXIS  = 11'b00000010000,
        S_ADIV  = 11'b00000100000,
        S_PREP  = 11'b00001000000,
        S_SCAN  = 11'b00010000000,
        S_MUL   = 11'b00100000000,
        S_FIN   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [CTU_W-1:0]    fw_reg, fh_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [CTU_W-1:0]    x_reg, y_reg;
    logic                axis_reg;
    logic [CTU_W-1:0]    len_reg, tgt_reg, start_reg;
    logic [TCNT_W:0]     n_reg;
    logic [TCNT_W-1:0]   nm1_reg, i_reg;
    logic [CTU_W-1:0]    q_reg;
    logic [TCNT_W-1:0]   r_reg, acc_reg;
    logic                found_reg;
    logic [TCNT_W-1:0]   fidx_reg;
    logic [CTU_W-1:0]    flo_reg, fhi_reg;
    logic [TCNT_W-1:0]   col_reg, row_reg;
    logic [CTU_W-1:0]    cs_lo_reg, cs_hi_reg, rs_hi_reg, rs_lo_reg;
    logic [TILE_W:0]     tile_reg;
    logic [COUNT_W-1:0]  prod_reg;
    result_t             res_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    // Picture size in CTUs.
    logic [LUMA_W:0]     ctu_m1, w_sum, h_sum;
    logic [CTU_W-1:0]    fw_c, fh_c;

    // Divider interface.
    logic                div_start, div_done;
    logic [CUR_W-1:0]    div_num, div_quo;
    logic [CTU_W-1:0]    div_den, div_rem;

    // Table memories.
    logic [SIZE_W-1:0]   col_rdata, row_rdata, tab;
    logic [5:0]          widx, ridx;
    logic                col_we, row_we;

    // Axis setup and scan step.
    logic [CTU_W-1:0]    ax_len, ax_tgt;
    logic [TCNT_W:0]     ax_n;
    logic [TCNT_W-1:0]   ax_nm1;
    logic [TCNT_W+1:0]   acc_sum;
    logic                carry, last, tab_err, hit;
    logic [CTU_W-1:0]    uni_next, s_next;
    logic [CTU_W:0]      sum_new;
    logic [TCNT_W-1:0]   f_idx;
    logic [CTU_W-1:0]    f_lo, f_hi;
    logic [TCNT_W:0]     cols_n, rows_n;

    // Final address.
    logic                xend, yend, last_tile;
    result_t             fin_res;
    logic                basic_err;

    assign ctu_m1 = (LUMA_W + 1)'((15'(1) << cfg.log2) - 15'(1));
    assign w_sum  = {1'b0, cfg.pic_w} + ctu_m1;
    assign h_sum  = {1'b0, cfg.pic_h} + ctu_m1;
    assign fw_c   = CTU_W'(w_sum >> cfg.log2);
    assign fh_c   = CTU_W'(h_sum >> cfg.log2);
    assign cols_n = {1'b0, cfg.cols_m1} + 1'b1;
    assign rows_n = {1'b0, cfg.rows_m1} + 1'b1;

    tsna_div #(
        .NUM_W (CUR_W),
        .DEN_W (CTU_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // Table writes come straight from the command; reads walk the scan index.
    assign widx   = {1'b0, cmd.index};
    assign ridx   = (state_reg == S_SCAN) ? (6'({1'b0, i_reg}) + 6'd1) : 6'd0;
    assign col_we = (state_reg == S_IDLE) && cmd_valid && (cmd.kind == KIND_LOAD_COL);
    assign row_we = (state_reg == S_IDLE) && cmd_valid && (cmd.kind == KIND_LOAD_ROW);

    tsna_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_TILE_COLS)
    ) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (widx[CIW-1:0]),
        .wdata (cmd.size),
        .raddr (ridx[CIW-1:0]),
        .rdata (col_rdata)
    );

    tsna_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_TILE_ROWS)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (widx[RIW-1:0]),
        .wdata (cmd.size),
        .raddr (ridx[RIW-1:0]),
        .rdata (row_rdata)
    );

    // Axis selection and one step of the boundary walk.
    always_comb
    begin
        ax_len   = axis_reg ? fh_reg : fw_reg;
        ax_tgt   = axis_reg ? y_reg : x_reg;
        ax_n     = axis_reg ? rows_n : cols_n;
        ax_nm1   = axis_reg ? cfg.rows_m1 : cfg.cols_m1;
        tab      = axis_reg ? row_rdata : col_rdata;
        acc_sum  = {2'b00, acc_reg} + {2'b00, r_reg};
        carry    = acc_sum >= {1'b0, n_reg};
        uni_next = start_reg + q_reg + CTU_W'(carry);
        sum_new  = {1'b0, start_reg} + {5'b00000, tab};
        last     = (i_reg == nm1_reg);
        s_next   = last ? len_reg : (cfg.uniform ? uni_next : sum_new[CTU_W-1:0]);
        tab_err  = !cfg.uniform && !last &&
                   ((tab == '0) || (sum_new >= {1'b0, len_reg}));
        hit      = !found_reg && (tgt_reg < s_next);
        f_idx    = found_reg ? fidx_reg : i_reg;
        f_lo     = found_reg ? flo_reg : start_reg;
        f_hi     = found_reg ? fhi_reg : s_next;
    end

    // Divider operand selection.
    always_comb
    begin
        div_start = 1'b0;
        div_num   = {{(CUR_W-CTU_W){1'b0}}, ax_len};
        div_den   = {{(CTU_W-TCNT_W-1){1'b0}}, ax_n};
        if (state_reg == S_CHECK)
        begin
            div_num   = cmd_reg.cur;
            div_den   = fw_reg;
            div_start = !basic_err;
        end
        else if (state_reg == S_AXIS)
        begin
            div_start = cfg.uniform && ({{(CTU_W-TCNT_W-1){1'b0}}, ax_n} <= ax_len);
        end
    end

    assign basic_err = (fw_reg == '0) || (fh_reg == '0) || (count_reg > COUNT_LIMIT) ||
                       (32'(cols_n) > MAX_TILE_COLS) || (32'(rows_n) > MAX_TILE_ROWS) ||
                       ({{(COUNT_W-CUR_W){1'b0}}, cmd_reg.cur} >= count_reg);

    // Next address from the located tile.
    always_comb
    begin
        xend      = (x_reg == cs_hi_reg - 1'b1);
        yend      = (y_reg == rs_hi_reg - 1'b1);
        last_tile = (col_reg == cfg.cols_m1) && (row_reg == cfg.rows_m1);
        fin_res   = '0;
        fin_res.tile = tile_reg[TILE_W-1:0];
        if (xend && yend)
        begin
            if (last_tile)
            begin
                fin_res.next_addr = count_reg[NEXT_W-1:0];
                fin_res.pic_end   = 1'b1;
            end
            else if (col_reg != cfg.cols_m1)
            begin
                fin_res.next_addr = prod_reg[NEXT_W-1:0] +
                                    {{(NEXT_W-CTU_W){1'b0}}, cs_hi_reg};
            end
            else
            begin
                fin_res.next_addr = prod_reg[NEXT_W-1:0];
            end
        end
        else if (xend)
        begin
            fin_res.next_addr = {1'b0, cmd_reg.cur} +
                                {{(NEXT_W-CTU_W){1'b0}}, fw_reg} -
                                {{(NEXT_W-CTU_W){1'b0}}, cs_hi_reg - cs_lo_reg} + 1'b1;
        end
        else
        begin
            fin_res.next_addr = {1'b0, cmd_reg.cur} + 1'b1;
        end
    end

    // Sequencer state transitions.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (cmd.kind == KIND_QUERY) ? S_SIZE : S_OUT;
                end
            end
            S_SIZE:
                state_next = S_CHECK;
            S_CHECK:
                state_next = basic_err ? S_OUT : S_XY;
            S_XY:
            begin
                if (div_done)
                begin
                    state_next = S_AXIS;
                end
            end
            S_AXIS:
            begin
                if (cfg.uniform)
                begin
                    state_next = div_start ? S_ADIV : S_OUT;
                end
                else
                begin
                    state_next = S_PREP;
                end
            end
            S_ADIV:
            begin
                if (div_done)
                begin
                    state_next = S_SCAN;
                end
            end
            S_PREP:
                state_next = S_SCAN;
            S_SCAN:
            begin
                if (tab_err)
                begin
                    state_next = S_OUT;
                end
                else if (last)
                begin
                    state_next = axis_reg ? S_MUL : S_AXIS;
                end
            end
            S_MUL:
                state_next = S_FIN;
            S_FIN:
                state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign cmd_ready = (state_reg == S_IDLE);

    // Control registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_OUT) && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && (!out_valid_reg || m_tready))
        begin
            out_reg <= res_reg;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg  <= cmd;
                fw_reg   <= fw_c;
                fh_reg   <= fh_c;
                res_reg  <= '0;
                axis_reg <= 1'b0;
            end
            S_SIZE:
                count_reg <= {{(COUNT_W-CTU_W){1'b0}}, fw_reg} *
                             {{(COUNT_W-CTU_W){1'b0}}, fh_reg};
            S_CHECK:
                res_reg.err <= basic_err;
            S_XY:
            begin
                x_reg <= div_rem;
                y_reg <= div_quo[CTU_W-1:0];
            end
            S_AXIS:
            begin
                len_reg   <= ax_len;
                tgt_reg   <= ax_tgt;
                n_reg     <= ax_n;
                nm1_reg   <= ax_nm1;
                i_reg     <= '0;
                start_reg <= '0;
                acc_reg   <= '0;
                found_reg <= 1'b0;
                if (cfg.uniform && !div_start)
                begin
                    res_reg.err <= 1'b1;
                end
            end
            S_ADIV:
            begin
                q_reg <= div_quo[CTU_W-1:0];
                r_reg <= div_rem[TCNT_W-1:0];
            end
            S_SCAN:
            begin
                if (tab_err)
                begin
                    res_reg.err <= 1'b1;
                end
                i_reg     <= i_reg + 1'b1;
                start_reg <= s_next;
                acc_reg   <= carry ? TCNT_W'(acc_sum - {1'b0, n_reg}) : acc_sum[TCNT_W-1:0];
                if (hit)
                begin
                    found_reg <= 1'b1;
                    fidx_reg  <= i_reg;
                    flo_reg   <= start_reg;
                    fhi_reg   <= s_next;
                end
                if (last)
                begin
                    axis_reg <= 1'b1;
                    if (axis_reg)
                    begin
                        row_reg   <= f_idx;
                        rs_lo_reg <= f_lo;
                        rs_hi_reg <= f_hi;
                    end
                    else
                    begin
                        col_reg   <= f_idx;
                        cs_lo_reg <= f_lo;
                        cs_hi_reg <= f_hi;
                    end
                end
            end
            S_MUL:
            begin
                tile_reg <= {{(TILE_W+1-TCNT_W){1'b0}}, row_reg} *
                            {{(TILE_W-TCNT_W){1'b0}}, cols_n} +
                            {{(TILE_W+1-TCNT_W){1'b0}}, col_reg};
                prod_reg <= {{(COUNT_W-CTU_W){1'b0}},
                             ((col_reg != cfg.cols_m1) ? rs_lo_reg : rs_hi_reg)} *
                            {{(COUNT_W-CTU_W){1'b0}}, fw_reg};
            end
            S_FIN:
                res_reg <= fin_res;
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.tile, out_reg.next_addr};
    assign m_tlast  = out_reg.pic_end;
    assign m_tuser  = out_reg.err;

endmodule

/* hdl/tile_scan_next_ctu_address_core.sv */
// Top level of the tile-scan next-CTU-address unit: configuration registers and wiring.
`timescale 1ns / 1ps
//
// Input stream (s_*): each beat carries an action in tuser. Actions load a tile
// column width or row height table entry, or query the next raster address in
// tile scan for a given CTU. Every accepted beat gives exactly one result beat.
// Output stream (m_*): next raster address and tile index in tdata, picture end
// in tlast, geometry error in tuser.
// Configuration channel (cfg_*): register index and data; always ready. It is to be
// written only while no beat is in flight; the block itself does not enforce this.
// A query first finds the CTU position in the shared bit-serial divider. Then, per
// axis, it sets up either the uniform spacing (again in the divider) or the
// tables, and walks the tile boundaries. Beats are handled one at a time.
// A two-beat command queue lets the input side keep accepting while a query runs,
// and the output register holds a result until the receiver takes it; a stalled
// receiver stalls the sequencer, then the queue fills and s_tready drops.
// Reset restores the register defaults (1920x1080, 64-sample CTUs, one tile,
// uniform); the width and height tables hold nothing until loaded.
//

module tile_scan_next_ctu_address_core #(
    parameter int MAX_TILE_COLS = 32,
    parameter int MAX_TILE_ROWS = 32,
    parameter int ADDR_BITS     = 18
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Fields from bit 0: entry_index[4:0], entry_size[14:5], cur_raster_addr[32:15]
    input  logic [39:0]                       s_tdata,
    // Fields from bit 0: action[1:0]
    input  logic [tsna_pkg::ACTION_W-1:0]     s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: next_raster_addr[18:0], tile_index[28:19]
    output logic [31:0]                       m_tdata,
    // Field: picture_end
    output logic                              m_tlast,
    // Field: geometry_error
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsna_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsna_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import tsna_pkg::*;

    cfg_t  cfg_reg;
    logic  cmd_valid, cmd_ready;
    cmd_t  cmd;

    assign cfg_ready = 1'b1;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pic_w   <= 14'd1920;
            cfg_reg.pic_h   <= 14'd1080;
            cfg_reg.log2    <= 3'd6;
            cfg_reg.cols_m1 <= '0;
            cfg_reg.rows_m1 <= '0;
            cfg_reg.uniform <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PIC_W:   cfg_reg.pic_w   <= cfg_data[LUMA_W-1:0];
                CFG_PIC_H:   cfg_reg.pic_h   <= cfg_data[LUMA_W-1:0];
                CFG_LOG2:    cfg_reg.log2    <= cfg_data[LOG2_W-1:0];
                CFG_COLS_M1: cfg_reg.cols_m1 <= cfg_data[TCNT_W-1:0];
                CFG_ROWS_M1: cfg_reg.rows_m1 <= cfg_data[TCNT_W-1:0];
                CFG_UNIFORM: cfg_reg.uniform <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    tsna_front #(
        .MAX_TILE_COLS (MAX_TILE_COLS),
        .MAX_TILE_ROWS (MAX_TILE_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    tsna_back #(
        .MAX_TILE_COLS (MAX_TILE_COLS),
        .MAX_TILE_ROWS (MAX_TILE_ROWS),
        .ADDR_BITS     (ADDR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
